// ----- rtl/lap5_pkg.sv -----
// Shared constants and types for the five-point Laplacian stencil block.
// No dependencies; every other file in rtl/ but lap5_line_ram refers to this package by scoped names.
`default_nettype none

package lap5_pkg;

    // Default sizing for the top-level parameters
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_SAMPLE_BITS = 32;

    // Configuration port
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 1'd1;

    // Smallest legal grid edge
    localparam int MIN_SIZE = 2;

    // One input can release up to three results
    localparam int NUM_RES   = 3;
    localparam int RES_CNT_W = 2;

    // Position flags of a sample, decoded when it is taken in
    typedef struct packed {
        logic first_row;
        logic second_row;
        logic last_row;
        logic first_col;
        logic second_col;
        logic last_col;
    } pos_flags_t;

endpackage

`default_nettype wire

// ----- rtl/lap5_line_ram.sv -----
// Single line store: one write port and one registered read port.
// Uses no package items; instantiated twice by the top level as a ping-pong pair.
`default_nettype none

module lap5_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] line_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Read returns the old contents when the same entry is written in that cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/lap5_stencil.sv -----
// Stencil stage: holds one sample with its line-store read data, keeps the
// sliding window of neighbours and ghosts, and forms up to three results.
// Depends on lap5_pkg (pos_flags_t, NUM_RES, RES_CNT_W).
`default_nettype none

module lap5_stencil #(
    parameter int SAMPLE_BITS = 32,
    parameter int ROW_W       = 10,
    parameter int COL_W       = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // new sample, valid on in_fire
    input  wire logic                          in_fire,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] in_top,
    input  wire logic signed [SAMPLE_BITS-1:0] in_bottom,
    input  wire logic signed [SAMPLE_BITS-1:0] in_left,
    input  wire logic signed [SAMPLE_BITS-1:0] in_right,
    input  wire lap5_pkg::pos_flags_t          in_pos,
    input  wire logic [ROW_W-1:0]              in_row,
    input  wire logic [COL_W-1:0]              in_col,
    // line-store data for the held sample: row r-2 at c, row r-1 at c+1
    input  wire logic signed [SAMPLE_BITS-1:0] up_rd,
    input  wire logic signed [SAMPLE_BITS-1:0] mid_next_rd,
    // result buffer can take a new group
    input  wire logic                          buf_free,
    output logic                               in_ready,
    output logic                               res_load,
    output logic [lap5_pkg::RES_CNT_W-1:0]     res_count,
    output logic signed [SAMPLE_BITS+2:0]      res_lap [lap5_pkg::NUM_RES],
    output logic [ROW_W-1:0]                   res_row [lap5_pkg::NUM_RES],
    output logic [COL_W-1:0]                   res_col [lap5_pkg::NUM_RES]
);

    localparam int OUT_W = SAMPLE_BITS + 3;

    // Held sample
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic signed [SAMPLE_BITS-1:0] top_reg;
    logic signed [SAMPLE_BITS-1:0] bot_reg;
    logic signed [SAMPLE_BITS-1:0] lg_reg;
    logic signed [SAMPLE_BITS-1:0] rg_reg;
    lap5_pkg::pos_flags_t          pos_reg;
    logic [ROW_W-1:0]              row_reg;
    logic [COL_W-1:0]              col_reg;

    // Window: previous row (middle line) and current row
    logic signed [SAMPLE_BITS-1:0] mid_ahead_reg;   // middle[c]
    logic signed [SAMPLE_BITS-1:0] mid_prev_reg;    // middle[c-1]
    logic signed [SAMPLE_BITS-1:0] first_reg;       // column zero of the last finished row
    logic signed [SAMPLE_BITS-1:0] cur_m1_reg;      // current row, c-1
    logic signed [SAMPLE_BITS-1:0] cur_m2_reg;      // current row, c-2
    logic signed [SAMPLE_BITS-1:0] prev_left_reg;
    logic signed [SAMPLE_BITS-1:0] prev_right_reg;
    logic signed [SAMPLE_BITS-1:0] prev_bottom_reg;

    logic                          s1_done;
    logic signed [SAMPLE_BITS-1:0] mid_c;
    logic [lap5_pkg::RES_CNT_W-1:0] count;

    function automatic logic signed [OUT_W-1:0] five_point(
        input logic signed [SAMPLE_BITS-1:0] up,
        input logic signed [SAMPLE_BITS-1:0] down,
        input logic signed [SAMPLE_BITS-1:0] left,
        input logic signed [SAMPLE_BITS-1:0] right,
        input logic signed [SAMPLE_BITS-1:0] ctr
    );
        logic signed [OUT_W-1:0] ue;
        logic signed [OUT_W-1:0] de;
        logic signed [OUT_W-1:0] le;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] ce;
        ue = OUT_W'(up);
        de = OUT_W'(down);
        le = OUT_W'(left);
        re = OUT_W'(right);
        ce = OUT_W'(ctr);
        return ue + de + le + re - (ce <<< 2);
    endfunction

    // Centre of the row-above result
    assign mid_c = pos_reg.first_col ? first_reg : mid_ahead_reg;

    // Result count: row zero gives none, the last row adds the trailing cells
    always_comb begin
        if (pos_reg.first_row) begin
            count = '0;
        end else begin
            count = lap5_pkg::RES_CNT_W'(1)
                  + lap5_pkg::RES_CNT_W'(pos_reg.last_row && !pos_reg.first_col)
                  + lap5_pkg::RES_CNT_W'(pos_reg.last_row && pos_reg.last_col);
        end
    end

    assign s1_done   = s1_valid_reg && ((count == '0) || buf_free);
    assign in_ready  = !s1_valid_reg || s1_done;
    assign res_load  = s1_valid_reg && (count != '0) && buf_free;
    assign res_count = count;

    // Cell (r-1, c)
    assign res_lap[0] = five_point(
        pos_reg.second_row ? top_reg : up_rd,
        smp_reg,
        pos_reg.first_col ? prev_left_reg : mid_prev_reg,
        pos_reg.last_col ? prev_right_reg : mid_next_rd,
        mid_c);
    assign res_row[0] = row_reg - 1'b1;
    assign res_col[0] = col_reg;

    // Cell (r, c-1), last row only
    assign res_lap[1] = five_point(
        mid_prev_reg,
        prev_bottom_reg,
        pos_reg.second_col ? lg_reg : cur_m2_reg,
        smp_reg,
        cur_m1_reg);
    assign res_row[1] = row_reg;
    assign res_col[1] = col_reg - 1'b1;

    // Cell (r, c), last sample of the grid only
    assign res_lap[2] = five_point(mid_c, bot_reg, cur_m1_reg, rg_reg, smp_reg);
    assign res_row[2] = row_reg;
    assign res_col[2] = col_reg;

    // Stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_done) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Held sample payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            smp_reg <= in_sample;
            top_reg <= in_top;
            bot_reg <= in_bottom;
            lg_reg  <= in_left;
            rg_reg  <= in_right;
            pos_reg <= in_pos;
            row_reg <= in_row;
            col_reg <= in_col;
        end
    end

    // Window shifts as each sample leaves the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_left_reg   <= '0;
            prev_right_reg  <= '0;
            prev_bottom_reg <= '0;
        end else if (s1_done) begin
            prev_bottom_reg <= bot_reg;
            if (pos_reg.last_col) begin
                prev_left_reg  <= lg_reg;
                prev_right_reg <= rg_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_done) begin
            mid_ahead_reg <= mid_next_rd;
            mid_prev_reg  <= mid_c;
            cur_m2_reg    <= cur_m1_reg;
            cur_m1_reg    <= smp_reg;
            if (pos_reg.first_col) begin
                first_reg <= smp_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lap5_out_buf.sv -----
// Result buffer: takes a group of one to three results and hands them out in
// order, flagging the last one of the group. Depends on lap5_pkg (NUM_RES, RES_CNT_W).
`default_nettype none

module lap5_out_buf #(
    parameter int LAP_W = 35,
    parameter int ROW_W = 10,
    parameter int COL_W = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire logic [lap5_pkg::RES_CNT_W-1:0] load_count,
    input  wire logic [LAP_W-1:0]               load_lap [lap5_pkg::NUM_RES],
    input  wire logic [ROW_W-1:0]               load_row [lap5_pkg::NUM_RES],
    input  wire logic [COL_W-1:0]               load_col [lap5_pkg::NUM_RES],
    output logic                                free,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [LAP_W-1:0]                    m_lap,
    output logic [ROW_W-1:0]                    m_row,
    output logic [COL_W-1:0]                    m_col,
    output logic                                m_last
);

    logic                           busy_reg;
    logic [lap5_pkg::RES_CNT_W-1:0] cnt_reg;
    logic [lap5_pkg::RES_CNT_W-1:0] idx_reg;
    logic [LAP_W-1:0]               lap_reg [lap5_pkg::NUM_RES];
    logic [ROW_W-1:0]               row_reg [lap5_pkg::NUM_RES];
    logic [COL_W-1:0]               col_reg [lap5_pkg::NUM_RES];
    logic                           is_last;

    assign is_last = (idx_reg == lap5_pkg::RES_CNT_W'(cnt_reg - 1'b1));
    assign m_valid = busy_reg;
    assign m_last  = is_last;
    assign m_lap   = lap_reg[idx_reg];
    assign m_row   = row_reg[idx_reg];
    assign m_col   = col_reg[idx_reg];
    // Free now, or the final transaction of the group completes this cycle
    assign free    = !busy_reg || (m_ready && is_last);

    // Group control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= load_count;
            idx_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (is_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            lap_reg <= load_lap;
            row_reg <= load_row;
            col_reg <= load_col;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/laplace_five_point_stencil.sv -----
// Top level of the five-point Laplacian stencil: raster counters, config
// registers, two ping-pong line stores, stencil stage and result buffer.
// Depends on lap5_pkg, lap5_line_ram, lap5_stencil, lap5_out_buf.
//
//  Channel | Dir | Handshake          | Payload (low bit first)
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: sample, top_ghost, bottom_ghost,
//          |     |                    |        left_ghost, right_ghost
//  m_      | out | m_tvalid/m_tready  | tdata: laplacian, out_row, out_col;
//          |     |                    | tlast: last_of_run
//  cfg_    | in  | cfg_we             | cfg_index 0 grid_rows, 1 grid_cols
//
// One sample per cycle sustained while m_tready is high. The line-store read is
// registered alongside the held sample in the stencil stage, and its results are
// registered in the result buffer, from which a group leaves one result a cycle
// while m_tready is high. In the last row a sample past column zero yields two or
// three results, and the input stalls while the result buffer drains them.
// Reset is synchronous and needs no clearing pass; any config write restarts the
// raster at row zero, column zero.
`default_nettype none

module laplace_five_point_stencil #(
    parameter int MAX_COLS    = lap5_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = lap5_pkg::DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = lap5_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // sample, top_ghost, bottom_ghost, left_ghost, right_ghost
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [((5*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // laplacian, out_row, out_col, zero pad
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    output logic [((SAMPLE_BITS+3+$clog2(MAX_ROWS)+$clog2(MAX_COLS)+7)/8)*8-1:0] m_tdata,
    output logic                                         m_tlast,
    input  wire logic                                    cfg_we,
    input  wire logic [lap5_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [lap5_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int OUT_W  = SAMPLE_BITS + 3;
    localparam int OUT_TW = ((OUT_W + ROW_W + COL_W + 7) / 8) * 8;

    // Raster position and sizes (last index, already clamped)
    logic [ROW_W-1:0] row_reg,       row_next;
    logic [COL_W-1:0] col_reg,       col_next;
    logic [ROW_W-1:0] rows_last_reg, rows_last_next;
    logic [COL_W-1:0] cols_last_reg, cols_last_next;
    logic             bank_reg,      bank_next;
    logic             rd_bank_reg;

    logic                 in_fire;
    lap5_pkg::pos_flags_t pos;
    logic [COL_W-1:0]     col_plus;

    logic signed [SAMPLE_BITS-1:0] f_sample;
    logic signed [SAMPLE_BITS-1:0] f_top;
    logic signed [SAMPLE_BITS-1:0] f_bottom;
    logic signed [SAMPLE_BITS-1:0] f_left;
    logic signed [SAMPLE_BITS-1:0] f_right;

    logic                   a_wr_en, b_wr_en;
    logic [COL_W-1:0]       a_rd_addr, b_rd_addr;
    logic [SAMPLE_BITS-1:0] a_rd_data, b_rd_data;
    logic signed [SAMPLE_BITS-1:0] up_rd, mid_next_rd;

    logic                            buf_free;
    logic                            res_load;
    logic [lap5_pkg::RES_CNT_W-1:0]  res_count;
    logic signed [OUT_W-1:0]         res_lap [lap5_pkg::NUM_RES];
    logic [OUT_W-1:0]                res_lap_u [lap5_pkg::NUM_RES];
    logic [ROW_W-1:0]                res_row [lap5_pkg::NUM_RES];
    logic [COL_W-1:0]                res_col [lap5_pkg::NUM_RES];

    logic [OUT_W-1:0] m_lap;
    logic [ROW_W-1:0] m_row;
    logic [COL_W-1:0] m_col;

    // Input field unpacking
    assign f_sample = s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
    assign f_top    = s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
    assign f_bottom = s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign f_left   = s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
    assign f_right  = s_tdata[4*SAMPLE_BITS +: SAMPLE_BITS];

    assign in_fire  = s_tvalid && s_tready;
    assign col_plus = col_reg + 1'b1;

    // Position decode
    assign pos.first_row  = (row_reg == '0);
    assign pos.second_row = (row_reg == ROW_W'(1));
    assign pos.last_row   = (row_reg == rows_last_reg);
    assign pos.first_col  = (col_reg == '0);
    assign pos.second_col = (col_reg == COL_W'(1));
    assign pos.last_col   = (col_reg == cols_last_reg);

    // Config decode and raster advance
    always_comb begin
        row_next       = row_reg;
        col_next       = col_reg;
        bank_next      = bank_reg;
        rows_last_next = rows_last_reg;
        cols_last_next = cols_last_reg;
        if (in_fire && pos.last_col) begin
            bank_next = !bank_reg;
        end
        if (cfg_we) begin
            unique case (cfg_index)
                lap5_pkg::REG_GRID_ROWS: begin
                    if (cfg_wdata < lap5_pkg::CFG_DATA_W'(lap5_pkg::MIN_SIZE)) begin
                        rows_last_next = ROW_W'(lap5_pkg::MIN_SIZE - 1);
                    end else if (32'(cfg_wdata) > 32'(MAX_ROWS)) begin
                        rows_last_next = ROW_W'(MAX_ROWS - 1);
                    end else begin
                        rows_last_next = ROW_W'(cfg_wdata - 1'b1);
                    end
                end
                lap5_pkg::REG_GRID_COLS: begin
                    if (cfg_wdata < lap5_pkg::CFG_DATA_W'(lap5_pkg::MIN_SIZE)) begin
                        cols_last_next = COL_W'(lap5_pkg::MIN_SIZE - 1);
                    end else if (32'(cfg_wdata) > 32'(MAX_COLS)) begin
                        cols_last_next = COL_W'(MAX_COLS - 1);
                    end else begin
                        cols_last_next = COL_W'(cfg_wdata - 1'b1);
                    end
                end
                default: begin
                end
            endcase
            row_next = '0;
            col_next = '0;
        end else if (in_fire) begin
            if (pos.last_col) begin
                col_next = '0;
                row_next = pos.last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_plus;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            bank_reg      <= 1'b0;
            rows_last_reg <= ROW_W'(lap5_pkg::MIN_SIZE - 1);
            cols_last_reg <= COL_W'(lap5_pkg::MIN_SIZE - 1);
        end else begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            bank_reg      <= bank_next;
            rows_last_reg <= rows_last_next;
            cols_last_reg <= cols_last_next;
        end
    end

    // Bank that was the upper line when the held sample was read
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rd_bank_reg <= bank_reg;
        end
    end

    // Ping-pong line stores: the upper bank is read at c and rewritten with the
    // sample, the middle bank is read one column ahead
    assign a_wr_en   = in_fire && !bank_reg;
    assign b_wr_en   = in_fire && bank_reg;
    assign a_rd_addr = bank_reg ? col_plus : col_reg;
    assign b_rd_addr = bank_reg ? col_reg : col_plus;

    lap5_line_ram #(
        .DEPTH  (MAX_COLS),
        .DATA_W (SAMPLE_BITS)
    ) u_line_a (
        .aclk    (aclk),
        .wr_en   (a_wr_en),
        .wr_addr (col_reg),
        .wr_data (f_sample),
        .rd_en   (in_fire),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    lap5_line_ram #(
        .DEPTH  (MAX_COLS),
        .DATA_W (SAMPLE_BITS)
    ) u_line_b (
        .aclk    (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (col_reg),
        .wr_data (f_sample),
        .rd_en   (in_fire),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    assign up_rd       = rd_bank_reg ? b_rd_data : a_rd_data;
    assign mid_next_rd = rd_bank_reg ? a_rd_data : b_rd_data;

    // Stencil stage
    lap5_stencil #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ROW_W       (ROW_W),
        .COL_W       (COL_W)
    ) u_stencil (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_sample   (f_sample),
        .in_top      (f_top),
        .in_bottom   (f_bottom),
        .in_left     (f_left),
        .in_right    (f_right),
        .in_pos      (pos),
        .in_row      (row_reg),
        .in_col      (col_reg),
        .up_rd       (up_rd),
        .mid_next_rd (mid_next_rd),
        .buf_free    (buf_free),
        .in_ready    (s_tready),
        .res_load    (res_load),
        .res_count   (res_count),
        .res_lap     (res_lap),
        .res_row     (res_row),
        .res_col     (res_col)
    );

    always_comb begin
        for (int i = 0; i < lap5_pkg::NUM_RES; i++) begin
            res_lap_u[i] = res_lap[i];
        end
    end

    // Result buffer
    lap5_out_buf #(
        .LAP_W (OUT_W),
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_load),
        .load_count (res_count),
        .load_lap   (res_lap_u),
        .load_row   (res_row),
        .load_col   (res_col),
        .free       (buf_free),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_lap      (m_lap),
        .m_row      (m_row),
        .m_col      (m_col),
        .m_last     (m_tlast)
    );

    assign m_tdata = OUT_TW'({m_col, m_row, m_lap});

    // Grid end wraps the raster back to the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && pos.last_row && pos.last_col |=> (row_reg == '0) && (col_reg == '0))
        else $error("raster did not wrap at end of grid");

    // Line stores swap exactly at each row end
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && pos.last_col |=> bank_reg != $past(bank_reg))
        else $error("line store banks did not swap at row end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !pos.last_col |=> bank_reg == $past(bank_reg))
        else $error("line store banks swapped inside a row");

    // Column counter stays inside the configured width
    assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= cols_last_reg)
        else $error("column counter beyond grid width");

endmodule

`default_nettype wire
